### sv/pse_pkg.sv
`default_nettype none
// ============================================================================
// pse_pkg
// Types, widths, codes and helper functions shared by the position smoothing
// extrapolator modules.
// ============================================================================
package pse_pkg;

    // History depth; the circular history addressing wraps on a power of two.
    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int N_W    = $clog2(DEPTH + 1);
    localparam int X_W    = $clog2(7 * DEPTH + 1);
    localparam int WBASE  = 50;
    localparam int W_W    = $clog2(WBASE + DEPTH);
    localparam int NINE_W = $clog2(9 * DEPTH + 1);
    localparam int SUM_W  = 32 + PTR_W + 1;
    localparam int ACC_W  = 32 + W_W + PTR_W + 1;
    localparam int NUM_W  = ACC_W + NINE_W + 2;
    localparam int DEN_W  = $clog2(10 * (WBASE * DEPTH + DEPTH * DEPTH / 2) + 1);
    localparam int DIV_M  = NUM_W + 1;
    localparam int DCNT_W = $clog2(DIV_M);
    localparam int Q_W    = DIV_M + 1;
    localparam int SAT_W  = Q_W + 1;

    typedef logic [2:0][31:0] t_vec;
    typedef logic signed [SAT_W-1:0] t_wide;

    typedef struct packed {
        t_vec raw;
        t_vec filt;
        t_vec step;
        t_vec accel;
    } t_row;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [9:0]         frame_rate;
        logic               direct_follow;
    } t_in;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_RAW,
        S_RAWW,
        S_FILT,
        S_DIVF,
        S_TAKEF,
        S_WRITE,
        S_EXT,
        S_EXTW,
        S_MUL,
        S_DIVE,
        S_WAITE,
        S_TARGET,
        S_FINISH
    } t_state;

    typedef enum logic {
        RD_RAW,
        RD_EXT
    } t_rdmode;

    typedef struct packed {
        logic             load_in;
        logic             prep;
        logic             rd_en;
        t_rdmode          rd_mode;
        logic [PTR_W-1:0] rd_idx;
        logic             div_filt;
        logic             take_filt;
        logic             write_row;
        logic             mul;
        logic             div_ext;
        logic             set_target;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic             rate_zero;
        logic             direct;
        logic             e_zero;
        logic             l_le1;
        logic [PTR_W-1:0] raw_last;
        logic [PTR_W-1:0] ext_last;
        logic             div_done;
    } t_sts;

    function automatic logic [31:0] sat32(input t_wide v);
        logic [SAT_W-32:0] top;
        top = v[SAT_W-1:31];
        if ((&top) || !(|top)) begin
            return v[31:0];
        end
        return v[SAT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [X_W-1:0] div10(input logic [X_W-1:0] x);
        logic [X_W+15:0] p;
        p = x * 16'd52429;
        return X_W'(p >> 19);
    endfunction

endpackage
`default_nettype wire

### sv/pse_div.sv
`default_nettype none
// ============================================================================
// pse_div
// Three-lane restoring divider, one quotient bit per cycle; floor quotient of
// a signed numerator by a shared positive denominator.
// ============================================================================
module pse_div import pse_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num [3],
    input  wire logic [DEN_W-1:0]        i_den,
    output logic                         o_done,
    output logic signed [Q_W-1:0]        o_quo [3]
);

    logic              r_busy, r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg [3];
    logic [DIV_M-1:0]  r_mag [3];
    logic [DEN_W-1:0]  r_rem [3];

    logic [DIV_M-1:0]  w_abs   [3];
    logic [DIV_M-1:0]  n_mag   [3];
    logic [DEN_W-1:0]  n_rem   [3];

    always_comb begin
        logic signed [DIV_M-1:0] ext;
        logic [DEN_W:0]          t;
        logic                    ge;
        for (int c = 0; c < 3; c++) begin
            ext = i_num[c];
            // floor for negatives: -ceil(|a|/d) with |a|+d-1 = ~a + d
            w_abs[c] = i_num[c][NUM_W-1] ? (~ext + DIV_M'(i_den)) : ext;
            t  = {r_rem[c], r_mag[c][DIV_M-1]};
            ge = (t >= {1'b0, r_den});
            n_rem[c] = ge ? DEN_W'(t - {1'b0, r_den}) : DEN_W'(t);
            n_mag[c] = {r_mag[c][DIV_M-2:0], ge};
            o_quo[c] = r_neg[c] ? -$signed({1'b0, r_mag[c]}) : $signed({1'b0, r_mag[c]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DCNT_W'(DIV_M - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int c = 0; c < 3; c++) begin
                r_neg[c] <= i_num[c][NUM_W-1];
                r_mag[c] <= w_abs[c];
                r_rem[c] <= '0;
            end
        end else if (r_busy) begin
            for (int c = 0; c < 3; c++) begin
                r_mag[c] <= n_mag[c];
                r_rem[c] <= n_rem[c];
            end
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

### sv/pse_datapath.sv
`default_nettype none
// ============================================================================
// pse_datapath
// History memory, box filter sum, weighted multiply-accumulate, shared
// divider and target/output registers.
// ============================================================================
module pse_datapath import pse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    input  wire t_in  i_in_data,
    output t_out      o_out_data
);

    t_row               mem [DEPTH];
    t_row               r_q;
    logic               r_rd_ok;
    t_rdmode            r_rd_mode;
    logic [PTR_W-1:0]   r_rd_idx;
    logic               r_rd_v;
    logic [DEPTH-1:0]   r_valid;
    logic [PTR_W-1:0]   r_head;

    t_vec               r_pos, r_filt, r_oldf0, r_olds0, r_filte, r_held;
    logic [9:0]         r_rate;
    logic               r_direct;
    logic [PTR_W-1:0]   r_e, r_l;
    logic [NINE_W-1:0]  r_nine;
    logic [DEN_W-1:0]   r_den;
    logic signed [SUM_W-1:0] r_sum   [3];
    logic signed [ACC_W-1:0] r_acc_a [3];
    logic signed [ACC_W-1:0] r_acc_b [3];
    logic signed [NUM_W-1:0] r_pa    [3];
    logic signed [NUM_W-1:0] r_pb    [3];
    t_out               r_out;

    logic [PTR_W-1:0]   w_phys, w_wr_addr;
    t_row               w_row, w_new;
    t_vec               w_in_pos, w_filt_take, w_tgt;
    logic [W_W-1:0]     w_wa, w_wb;
    logic signed [ACC_W-1:0] w_ma [3];
    logic signed [ACC_W-1:0] w_mb [3];
    logic signed [NUM_W-1:0] w_pa [3];
    logic signed [NUM_W-1:0] w_pb [3];
    logic signed [NUM_W-1:0] w_num [3];
    logic [DEN_W-1:0]   w_den;
    logic               w_div_done;
    logic signed [Q_W-1:0] w_quo [3];
    logic [N_W-1:0]     w_n;
    logic [X_W-1:0]     w_e7, w_l4;
    logic [DEN_W-1:0]   w_den_e;

    assign w_phys    = r_head - i_cmd.rd_idx;
    assign w_wr_addr = r_head + PTR_W'(1);
    assign w_row     = r_rd_ok ? r_q : '0;
    assign w_in_pos  = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
    assign w_wa      = W_W'(WBASE) + W_W'(r_rd_idx);
    assign w_wb      = W_W'(WBASE) + W_W'(r_e) - W_W'(1) - W_W'(r_rd_idx);
    assign w_den     = i_cmd.div_filt ? DEN_W'(r_l) : r_den;

    assign w_n     = (r_rate >= 10'(DEPTH)) ? N_W'(DEPTH) : N_W'(r_rate);
    assign w_e7    = div10(X_W'(7 * w_n));
    assign w_l4    = div10(X_W'(4 * w_n));
    // ten times the weight prefix sum: 5 * E * (E + 99)
    assign w_den_e = DEN_W'(5 * PTR_W'(w_e7) * (W_W'(PTR_W'(w_e7)) + W_W'(99)));

    always_comb begin
        logic signed [32:0] d_step, d_acc;
        t_wide              sum;
        for (int c = 0; c < 3; c++) begin
            w_ma[c] = $signed(w_row.step[c]) * $signed({1'b0, w_wa});
            w_mb[c] = $signed(w_row.accel[c]) * $signed({1'b0, w_wb});
            w_pa[c] = $signed({1'b0, r_nine}) * r_acc_a[c];
            w_pb[c] = r_acc_b[c] * 10;
            w_num[c] = i_cmd.div_filt
                     ? NUM_W'(r_sum[c]) + $signed({1'b0, r_l >> 1})
                     : r_pa[c] + r_pb[c] + $signed({1'b0, r_den >> 1});
            w_filt_take[c] = (r_l <= PTR_W'(1)) ? r_pos[c] : sat32(t_wide'(w_quo[c]));

            w_new.raw[c]  = r_pos[c];
            w_new.filt[c] = r_filt[c];
            d_step = $signed(r_filt[c]) - $signed(r_oldf0[c]);
            w_new.step[c] = sat32(t_wide'(d_step));
            d_acc = $signed(w_new.step[c]) - $signed(r_olds0[c]);
            w_new.accel[c] = sat32(t_wide'(d_acc));

            sum = t_wide'(w_quo[c]) + t_wide'($signed(r_filte[c]));
            if (r_direct) begin
                w_tgt[c] = r_pos[c];
            end else if (r_e == '0) begin
                w_tgt[c] = r_filt[c];
            end else begin
                w_tgt[c] = sat32(sum);
            end
        end
    end

    pse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_filt | i_cmd.div_ext),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_row) begin
            mem[w_wr_addr] <= w_new;
        end
        if (i_cmd.rd_en) begin
            r_q <= mem[w_phys];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_rd_v  <= 1'b0;
            r_held  <= '0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            if (i_cmd.write_row) begin
                r_valid[w_wr_addr] <= 1'b1;
                r_head             <= w_wr_addr;
            end
            if (i_cmd.set_target) begin
                r_held <= w_tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok   <= r_valid[w_phys];
        r_rd_mode <= i_cmd.rd_mode;
        r_rd_idx  <= i_cmd.rd_idx;
        if (i_cmd.load_in) begin
            r_pos    <= w_in_pos;
            r_rate   <= i_in_data.frame_rate;
            r_direct <= i_in_data.direct_follow;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= $signed(w_in_pos[c]);
            end
        end
        if (i_cmd.prep) begin
            r_e    <= PTR_W'(w_e7);
            r_l    <= PTR_W'(w_l4);
            r_nine <= NINE_W'(9 * w_n);
            r_den  <= w_den_e;
        end
        if (r_rd_v) begin
            if (r_rd_mode == RD_RAW) begin
                if (r_rd_idx == '0) begin
                    r_oldf0 <= w_row.filt;
                    r_olds0 <= w_row.step;
                end
                if (r_l > PTR_W'(1)) begin
                    for (int c = 0; c < 3; c++) begin
                        r_sum[c] <= r_sum[c] + $signed(w_row.raw[c]);
                    end
                end
            end else begin
                if (r_rd_idx == r_e) begin
                    r_filte <= w_row.filt;
                end else begin
                    for (int c = 0; c < 3; c++) begin
                        r_acc_a[c] <= r_acc_a[c] + w_ma[c];
                        r_acc_b[c] <= r_acc_b[c] + w_mb[c];
                    end
                end
            end
        end
        if (i_cmd.take_filt) begin
            r_filt <= w_filt_take;
        end
        if (i_cmd.write_row) begin
            for (int c = 0; c < 3; c++) begin
                r_acc_a[c] <= '0;
                r_acc_b[c] <= '0;
            end
        end
        if (i_cmd.mul) begin
            for (int c = 0; c < 3; c++) begin
                r_pa[c] <= w_pa[c];
                r_pb[c] <= w_pb[c];
            end
        end
        if (i_cmd.load_out) begin
            r_out <= {r_held[0], r_held[1], r_held[2]};
        end
    end

    assign o_sts.rate_zero = (r_rate == '0);
    assign o_sts.direct    = r_direct;
    assign o_sts.e_zero    = (r_e == '0);
    assign o_sts.l_le1     = (r_l <= PTR_W'(1));
    assign o_sts.raw_last  = (r_l <= PTR_W'(1)) ? '0 : r_l - PTR_W'(2);
    assign o_sts.ext_last  = r_e;
    assign o_sts.div_done  = w_div_done;
    assign o_out_data      = r_out;

endmodule
`default_nettype wire

### sv/pse_ctrl.sv
`default_nettype none
// ============================================================================
// pse_ctrl
// Sequencer for one request: filter pass, history update, weighted pass,
// divisions and result hand-off.
// ============================================================================
module pse_ctrl import pse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_k, n_k;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_PREP;
            S_PREP:   n_state = i_sts.rate_zero ? S_FINISH : S_RAW;
            S_RAW:    if (r_k == i_sts.raw_last) n_state = S_RAWW;
            S_RAWW:   n_state = S_FILT;
            S_FILT:   n_state = i_sts.l_le1 ? S_TAKEF : S_DIVF;
            S_DIVF:   if (i_sts.div_done) n_state = S_TAKEF;
            S_TAKEF:  n_state = S_WRITE;
            S_WRITE:  n_state = (i_sts.direct || i_sts.e_zero) ? S_TARGET : S_EXT;
            S_EXT:    if (r_k == i_sts.ext_last) n_state = S_EXTW;
            S_EXTW:   n_state = S_MUL;
            S_MUL:    n_state = S_DIVE;
            S_DIVE:   n_state = S_WAITE;
            S_WAITE:  if (i_sts.div_done) n_state = S_TARGET;
            S_TARGET: n_state = S_FINISH;
            S_FINISH: if (w_slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.rd_mode = RD_RAW;
        o_cmd.rd_idx  = r_k;
        o_in_ready  = 1'b0;
        n_k         = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_PREP:   o_cmd.prep = 1'b1;
            S_RAW: begin
                o_cmd.rd_en = 1'b1;
                n_k         = r_k + 1'b1;
            end
            S_FILT:   o_cmd.div_filt   = !i_sts.l_le1;
            S_TAKEF:  o_cmd.take_filt  = 1'b1;
            S_WRITE:  o_cmd.write_row  = 1'b1;
            S_EXT: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_mode = RD_EXT;
                n_k           = r_k + 1'b1;
            end
            S_MUL:    o_cmd.mul        = 1'b1;
            S_DIVE:   o_cmd.div_ext    = 1'b1;
            S_TARGET: o_cmd.set_target = 1'b1;
            S_FINISH: o_cmd.load_out   = w_slot_free;
            default: ;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### sv/position_smoothing_extrapolator.sv
`default_nettype none
// ============================================================================
// position_smoothing_extrapolator
// Per-frame box filter and weighted step/acceleration extrapolation of a
// 3D Q16.16 position.
//
//   channel | ports                              | payload
//   in      | i_in_valid / o_in_ready            | i_in_data  (t_in)
//   out     | o_out_valid / i_out_ready          | o_out_data (t_out)
//
// One request at a time. The two divisions run in series on the shared divider,
// and the history reads take one row per cycle.
// Reset is synchronous, active low; histories read as zero until written.
// A result waits in the output register while the next request is accepted.
// ============================================================================
module position_smoothing_extrapolator import pse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pse_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !o_out_valid || i_out_ready)
        else $error("pending result overwritten");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.write_row |=> !w_cmd.write_row)
        else $error("history advanced twice");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// ============================================================================
// testbench
// Self-checking regression for the position smoothing extrapolator: a
// predictor follows the filter, the histories and the extrapolation, and a
// scoreboard compares every target against the queued prediction.
// ============================================================================
module testbench;
    import pse_pkg::*;

    localparam int HDEPTH = 64;

    class target_scoreboard;
        logic signed [31:0] raw_h [HDEPTH][3];
        logic signed [31:0] filt_h [HDEPTH][3];
        logic signed [31:0] step_h [HDEPTH][3];
        logic signed [31:0] accel_h [HDEPTH][3];
        logic signed [31:0] held [3];
        t_out pending [$];
        int mismatches;
        int checked;

        function new();
            for (int i = 0; i < HDEPTH; i++) begin
                for (int c = 0; c < 3; c++) begin
                    raw_h[i][c] = 0;
                    filt_h[i][c] = 0;
                    step_h[i][c] = 0;
                    accel_h[i][c] = 0;
                end
            end
            for (int c = 0; c < 3; c++) held[c] = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint round_div(longint num, longint den);
            longint a;
            longint q;
            a = num + den / 2;
            q = a / den;
            if ((a % den) != 0 && a < 0) q--;
            return q;
        endfunction

        function longint wsum(int k);
            longint s;
            s = 0;
            for (int i = 0; i <= k; i++) s += 50 + i;
            return s;
        endfunction

        function void note_request(t_in req);
            int n;
            int e;
            int l;
            longint pos [3];
            longint sum;
            longint filt;
            longint a;
            longint b;
            longint tgt;
            t_out res;
            if (req.frame_rate != 0) begin
                n = (req.frame_rate < HDEPTH) ? int'(req.frame_rate) : HDEPTH;
                e = (7 * n) / 10;
                l = (4 * n) / 10;
                pos[0] = req.pos_x;
                pos[1] = req.pos_y;
                pos[2] = req.pos_z;
                for (int c = 0; c < 3; c++) begin
                    if (l <= 1) begin
                        filt = pos[c];
                    end else begin
                        sum = pos[c];
                        for (int i = 0; i < l - 1; i++) sum += raw_h[i][c];
                        filt = round_div(sum, l);
                    end
                    for (int i = HDEPTH - 1; i > 0; i--) begin
                        raw_h[i][c] = raw_h[i-1][c];
                        filt_h[i][c] = filt_h[i-1][c];
                        step_h[i][c] = step_h[i-1][c];
                        accel_h[i][c] = accel_h[i-1][c];
                    end
                    raw_h[0][c] = pos[c];
                    filt_h[0][c] = clip32(filt);
                    step_h[0][c] = clip32(longint'(filt_h[0][c]) - filt_h[1][c]);
                    accel_h[0][c] = clip32(longint'(step_h[0][c]) - step_h[1][c]);
                end
                for (int c = 0; c < 3; c++) begin
                    if (req.direct_follow) begin
                        tgt = pos[c];
                    end else if (e == 0) begin
                        tgt = filt_h[0][c];
                    end else begin
                        a = 0;
                        b = 0;
                        for (int i = 0; i < e; i++) begin
                            a += longint'(step_h[i][c]) * (50 + i);
                            b += longint'(accel_h[i][c]) * (50 + e - 1 - i);
                        end
                        tgt = longint'(filt_h[e][c])
                            + round_div(9 * n * a + 10 * b, 10 * wsum(e - 1));
                    end
                    held[c] = clip32(tgt);
                end
            end
            res.target_x = held[0];
            res.target_y = held[1];
            res.target_z = held[2];
            pending.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out exp_res;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_res = pending.pop_front();
            checked++;
            if (got.target_x !== exp_res.target_x || got.target_y !== exp_res.target_y
                    || got.target_z !== exp_res.target_z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h %h %h got %h %h %h",
                             exp_res.target_x, exp_res.target_y, exp_res.target_z,
                             got.target_x, got.target_y, got.target_z);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    t_out o_out_data;

    target_scoreboard sb = new();
    int sent = 0;
    int big_hold = 0;
    bit quiet = 0;

    position_smoothing_extrapolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_request(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    function automatic logic [31:0] pick_coord(int shape);
        case (shape)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    task automatic send_request(t_in req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_data <= req;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_fields(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [9:0] rate, logic dir);
        t_in req;
        req.pos_x = x;
        req.pos_y = y;
        req.pos_z = z;
        req.frame_rate = rate;
        req.direct_follow = dir;
        send_request(req);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_out_ready <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        forever begin
            @(posedge i_clk);
            if (big_hold > 0) begin
                i_out_ready <= 0;
                big_hold--;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(0, 3)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    initial begin
        t_in req;
        int shape;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 10'd1, 0);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 0);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 10'd64, 0);
        send_fields(32'h0, 32'h0, 32'h0, 10'd0, 1);
        send_fields(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 10'd0, 0);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 10'd65, 1);
        send_fields(32'hFFFF_FFFF, 32'h0001_0000, 32'h5555_5555, 10'd2, 0);
        send_fields(32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 10'd3, 0);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd5, 0);
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 10'd63, 0);
        send_fields(32'h0010_0000, 32'hFFF0_0000, 32'h0, 10'd4, 1);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 10'd512, 0);
        send_fields(32'h0, 32'hFFFF_FFFF, 32'h1, 10'd30, 0);
        drain();
        big_hold = 600;
        for (int k = 0; k < 6; k++)
            send_fields($urandom, $urandom, $urandom, 10'($urandom_range(1, 80)), 0);
        drain();
        repeat ($urandom_range(50, 300)) @(posedge i_clk);
        for (int k = 0; k < 1800; k++) begin
            if (k == 1500) quiet = 1;
            shape = $urandom_range(0, 9);
            if (shape < 6) begin
                req.pos_x = pick_coord(3);
                req.pos_y = pick_coord(3);
                req.pos_z = pick_coord(3);
            end else begin
                req.pos_x = pick_coord($urandom_range(0, 2));
                req.pos_y = pick_coord($urandom_range(0, 2));
                req.pos_z = pick_coord($urandom_range(0, 2));
            end
            case ($urandom_range(0, 9))
                0: req.frame_rate = 0;
                1: req.frame_rate = 10'($urandom);
                2: req.frame_rate = 10'($urandom_range(1, 4));
                default: req.frame_rate = 10'($urandom_range(1, 70));
            endcase
            req.direct_follow = ($urandom_range(0, 7) == 0);
            send_request(req);
        end
        drain();
        repeat (400) @(posedge i_clk);
        $display("Covered %0d requests, %0d targets checked: extreme positions, zero rate,",
                 sent, sb.checked);
        $display("direct follow, short and full-depth extrapolation, output back-pressure.");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout after %0d requests", sent);
        $display("Regression FAIL");
        $finish;
    end
endmodule

### sim.f
sv/pse_pkg.sv
sv/pse_div.sv
sv/pse_datapath.sv
sv/pse_ctrl.sv
sv/position_smoothing_extrapolator.sv
tb/testbench.sv
